// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master register access block.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Request codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Phase codes within one bus step
  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;
  localparam logic [1:0] PH_D = 2'd3;

  // Bits in one byte on the bus, and the mask of the bit sent first
  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [7:0] MSB_MASK  = 8'h80;

  // Transfer stage, one-hot
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_START  = 9'b000000010,
    ST_ADDRW  = 9'b000000100,
    ST_REG    = 9'b000001000,
    ST_VALUE  = 9'b000010000,
    ST_RSTART = 9'b000100000,
    ST_ADDRR  = 9'b001000000,
    ST_RECV   = 9'b010000000,
    ST_STOP   = 9'b100000000
  } i2cm_stage_t;

  // Complete controller state
  typedef struct packed {
    i2cm_stage_t stage;
    logic [1:0]  phase;
    logic [3:0]  bit_index;
    logic [7:0]  shift_reg;
    logic [6:0]  held_device;
    logic [7:0]  held_register;
    logic [7:0]  held_value;
    logic [7:0]  remaining_reads;
    logic        is_read;
    logic        nack_flag;
    logic        scl_reg;
    logic        sda_reg;
  } i2cm_state_t;

  // One input item (one bus tick)
  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_address;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_sample;
  } i2cm_item_t;

  // One result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       nack_seen;
    logic       busy_res;
    logic       transaction_done;
  } i2cm_res_t;

endpackage

// ===== rtl/core/i2cm_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_in_if / i2cm_out_if
// Valid/ready channels carrying bus ticks in and results out.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] dev_address;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic [7:0] read_count;
  logic       sda_sample;

  modport source (
    output valid, req_type, dev_address, reg_address, write_data, read_count,
           sda_sample,
    input  ready
  );
  modport sink (
    input  valid, req_type, dev_address, reg_address, write_data, read_count,
           sda_sample,
    output ready
  );
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       read_last;
  logic       nack_seen;
  logic       busy_res;
  logic       transaction_done;

  modport source (
    output valid, scl_level, sda_level, read_byte, read_valid, read_last,
           nack_seen, busy_res, transaction_done,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, read_byte, read_valid, read_last,
           nack_seen, busy_res, transaction_done,
    output ready
  );
endinterface

// ===== rtl/core/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and result logic for one bus phase tick.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::i2cm_state_t state_i,
  input  i2cm_pkg::i2cm_item_t  item_i,
  output i2cm_pkg::i2cm_state_t state_o,
  output i2cm_pkg::i2cm_res_t   res_o
);
  import i2cm_pkg::*;

  i2cm_state_t cur;
  i2cm_state_t nxt;
  i2cm_res_t   res;
  logic [7:0]  rem_dec;

  // Load a new request when idle, then apply one phase of the current stage
  always_comb begin
    cur = state_i;
    if (state_i.stage == ST_IDLE &&
        (item_i.req_type == REQ_WRITE || item_i.req_type == REQ_READ)) begin
      cur.held_device     = item_i.dev_address;
      cur.held_register   = item_i.reg_address;
      cur.held_value      = item_i.write_data;
      cur.is_read         = (item_i.req_type == REQ_READ);
      cur.remaining_reads = (item_i.req_type == REQ_READ) ? item_i.read_count : 8'd0;
      cur.nack_flag       = 1'b0;
      cur.stage           = ST_START;
      cur.phase           = PH_A;
    end

    nxt = cur;
    res = '0;
    rem_dec = (cur.remaining_reads != 8'd0) ? cur.remaining_reads - 8'd1 : 8'd0;

    unique case (cur.stage)
      ST_IDLE: begin
      end

      ST_START, ST_RSTART: begin
        unique case (cur.phase)
          PH_A: begin
            nxt.sda_reg = 1'b1;
            nxt.phase   = PH_B;
          end
          PH_B: begin
            nxt.scl_reg = 1'b1;
            nxt.phase   = PH_C;
          end
          PH_C: begin
            nxt.sda_reg = 1'b0;
            nxt.phase   = PH_D;
          end
          default: begin
            nxt.scl_reg   = 1'b0;
            nxt.stage     = (cur.stage == ST_START) ? ST_ADDRW : ST_ADDRR;
            nxt.shift_reg = {cur.held_device, (cur.stage == ST_RSTART)};
            nxt.bit_index = '0;
            nxt.phase     = PH_A;
          end
        endcase
      end

      ST_ADDRW, ST_REG, ST_VALUE, ST_ADDRR: begin
        if (cur.bit_index < BYTE_BITS) begin
          // Send one bit, MSB first
          unique case (cur.phase)
            PH_A: begin
              nxt.sda_reg = |(cur.shift_reg & MSB_MASK);
              nxt.phase   = PH_B;
            end
            PH_B: begin
              nxt.scl_reg = 1'b1;
              nxt.phase   = PH_C;
            end
            default: begin
              nxt.scl_reg   = 1'b0;
              nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
              nxt.bit_index = cur.bit_index + 4'd1;
              nxt.phase     = PH_A;
            end
          endcase
        end else begin
          // ACK slot: sample into the sticky flag, then move on regardless
          unique case (cur.phase)
            PH_A: begin
              nxt.sda_reg = 1'b1;
              nxt.phase   = PH_B;
            end
            PH_B: begin
              nxt.scl_reg = 1'b1;
              nxt.phase   = PH_C;
            end
            default: begin
              nxt.nack_flag = cur.nack_flag | item_i.sda_sample;
              nxt.scl_reg   = 1'b0;
              nxt.phase     = PH_A;
              if (cur.stage == ST_ADDRW) begin
                nxt.stage     = ST_REG;
                nxt.shift_reg = cur.held_register;
                nxt.bit_index = '0;
              end else if (cur.stage == ST_REG && cur.is_read) begin
                nxt.stage = ST_RSTART;
              end else if (cur.stage == ST_REG) begin
                nxt.stage     = ST_VALUE;
                nxt.shift_reg = cur.held_value;
                nxt.bit_index = '0;
              end else if (cur.stage == ST_ADDRR && cur.remaining_reads != 8'd0) begin
                nxt.stage     = ST_RECV;
                nxt.shift_reg = '0;
                nxt.bit_index = '0;
              end else begin
                nxt.stage = ST_STOP;
              end
            end
          endcase
        end
      end

      ST_RECV: begin
        if (cur.bit_index < BYTE_BITS) begin
          // Receive one bit into the LSB
          unique case (cur.phase)
            PH_A: begin
              nxt.sda_reg = 1'b1;
              nxt.phase   = PH_B;
            end
            PH_B: begin
              nxt.scl_reg = 1'b1;
              nxt.phase   = PH_C;
            end
            default: begin
              nxt.shift_reg = {cur.shift_reg[6:0], item_i.sda_sample};
              nxt.scl_reg   = 1'b0;
              nxt.bit_index = cur.bit_index + 4'd1;
              nxt.phase     = PH_A;
            end
          endcase
        end else begin
          // Master ACK, or NACK on the last byte, then report the byte
          unique case (cur.phase)
            PH_A: begin
              nxt.sda_reg = (cur.remaining_reads == 8'd1);
              nxt.phase   = PH_B;
            end
            PH_B: begin
              nxt.scl_reg = 1'b1;
              nxt.phase   = PH_C;
            end
            default: begin
              nxt.scl_reg         = 1'b0;
              res.read_valid      = 1'b1;
              res.read_byte       = cur.shift_reg;
              res.read_last       = (cur.remaining_reads == 8'd1);
              nxt.remaining_reads = rem_dec;
              nxt.phase           = PH_A;
              if (rem_dec == 8'd0) begin
                nxt.stage = ST_STOP;
              end else begin
                nxt.bit_index = '0;
                nxt.shift_reg = '0;
              end
            end
          endcase
        end
      end

      ST_STOP: begin
        unique case (cur.phase)
          PH_A: begin
            nxt.sda_reg = 1'b0;
            nxt.phase   = PH_B;
          end
          PH_B: begin
            nxt.scl_reg = 1'b1;
            nxt.phase   = PH_C;
          end
          default: begin
            nxt.sda_reg          = 1'b1;
            res.transaction_done = 1'b1;
            nxt.stage            = ST_IDLE;
            nxt.phase            = PH_A;
            nxt.bit_index        = '0;
          end
        endcase
      end

      // Meaningless stage codes: release the bus and go idle
      default: begin
        nxt.stage     = ST_IDLE;
        nxt.phase     = PH_A;
        nxt.bit_index = '0;
        nxt.scl_reg   = 1'b1;
        nxt.sda_reg   = 1'b1;
      end
    endcase

    res.scl_level = nxt.scl_reg;
    res.sda_level = nxt.sda_reg;
    res.nack_seen = nxt.nack_flag;
    res.busy_res  = (nxt.stage != ST_IDLE);
  end

  assign state_o = nxt;
  assign res_o   = res;

endmodule

// ===== rtl/core/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// I2C master for register writes and multi-byte register reads.
// ----------------------------------------------------------------------------
// Each item on in_ch is one bus phase tick: a request (ignored unless the
// controller is idle) plus the sampled SDA level. For every item accepted
// the block returns exactly one item on out_ch with the SCL and SDA levels
// to drive after that phase, any received byte with its last flag, the
// sticky NACK flag, busy and the stop-complete strobe.
// Each item passes the input register, then one pass of the phase logic into
// the result register. Throughput: one item per cycle while out_ch does not
// stall; the controller state advances once per item as it moves from the
// input register into the result register.
// Reset: controller idle, bus released, both registers empty.
// When out_ch stalls the result holds; the input register still takes
// one more item, after which in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
  input  logic            clk,
  input  logic            rst_n,
  i2cm_in_if.sink         in_ch,
  i2cm_out_if.source      out_ch
);
  import i2cm_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  i2cm_item_t  s1_item_r, s1_item_nxt;
  logic        out_valid_r, out_valid_nxt;
  i2cm_res_t   out_res_r, out_res_nxt;
  i2cm_state_t state_r, state_nxt;
  i2cm_state_t step_state;
  i2cm_res_t   step_res;
  logic        out_free;
  logic        s1_adv;
  logic        in_take;

  localparam i2cm_state_t STATE_RST = '{
    stage:           ST_IDLE,
    phase:           PH_A,
    bit_index:       4'd0,
    shift_reg:       8'd0,
    held_device:     7'd0,
    held_register:   8'd0,
    held_value:      8'd0,
    remaining_reads: 8'd0,
    is_read:         1'b0,
    nack_flag:       1'b0,
    scl_reg:         1'b1,
    sda_reg:         1'b1
  };

  // Handshake control
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Phase logic
  i2cm_step u_step (
    .state_i (state_r),
    .item_i  (s1_item_r),
    .state_o (step_state),
    .res_o   (step_res)
  );

  // Input register
  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !s1_adv);
    s1_item_nxt  = s1_item_r;
    if (in_take) begin
      s1_item_nxt.req_type    = in_ch.req_type;
      s1_item_nxt.dev_address = in_ch.dev_address;
      s1_item_nxt.reg_address = in_ch.reg_address;
      s1_item_nxt.write_data  = in_ch.write_data;
      s1_item_nxt.read_count  = in_ch.read_count;
      s1_item_nxt.sda_sample  = in_ch.sda_sample;
    end
  end

  // Advance controller state and result register together
  always_comb begin
    state_nxt     = s1_adv ? step_state : state_r;
    out_res_nxt   = s1_adv ? step_res : out_res_r;
    out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  // Drive result channel
  assign out_ch.valid            = out_valid_r;
  assign out_ch.scl_level        = out_res_r.scl_level;
  assign out_ch.sda_level        = out_res_r.sda_level;
  assign out_ch.read_byte        = out_res_r.read_byte;
  assign out_ch.read_valid       = out_res_r.read_valid;
  assign out_ch.read_last        = out_res_r.read_last;
  assign out_ch.nack_seen        = out_res_r.nack_seen;
  assign out_ch.busy_res         = out_res_r.busy_res;
  assign out_ch.transaction_done = out_res_r.transaction_done;

endmodule

// ===== rtl/core/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result channel of the I2C master.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic [7:0] read_byte,
  input logic       read_valid,
  input logic       read_last,
  input logic       nack_seen,
  input logic       busy_res,
  input logic       transaction_done
);

  // Stop completes with the bus released and the controller idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && transaction_done |-> !busy_res && scl_level && sda_level)
    else $error("stop completed without releasing the bus");

  // Last flag only with a reported byte
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_last |-> read_valid)
    else $error("read_last without read_valid");

  // A byte is reported mid-transaction with SCL pulled low
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_valid |-> busy_res && !scl_level && !transaction_done)
    else $error("received byte outside a transfer or with SCL high");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_byte) &&
      $stable(scl_level) && $stable(sda_level) && $stable(nack_seen))
    else $error("stalled result changed");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .scl_level        (out_ch.scl_level),
  .sda_level        (out_ch.sda_level),
  .read_byte        (out_ch.read_byte),
  .read_valid       (out_ch.read_valid),
  .read_last        (out_ch.read_last),
  .nack_seen        (out_ch.nack_seen),
  .busy_res         (out_ch.busy_res),
  .transaction_done (out_ch.transaction_done)
);
